// ===== rtl/box_mean_filter_2d_assert.svh =====
// Assertion macros shared by the box mean filter RTL.
`ifndef BOX_MEAN_FILTER_2D_ASSERT_SVH
`define BOX_MEAN_FILTER_2D_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define BMF_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define BMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bmf_pkg.sv =====
// Shared widths, register codes, result types and reciprocal table of the box mean filter.
package bmf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 3;
    localparam int MAX_HEIGHT     = 4096;

    localparam int PIX_W       = 8;
    localparam int VSUM_W      = 11;
    localparam int TOTAL_W     = 14;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 24;
    localparam int ROW_W       = 12;
    localparam int COL_OUT_W   = 10;
    localparam int RAD_W       = 2;
    localparam int FW_W        = 11;
    localparam int FH_W        = 13;
    localparam int IDX_W       = 4;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = 2;
    localparam int FIFO_DEPTH  = 8;

    localparam logic [REG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 2'd1;
    localparam logic [FW_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [FH_W-1:0]  HEIGHT_RESET = 13'd1024;

    localparam logic [RECIP_W-1:0] RECIP_AREA_1  = 25'd16777216;
    localparam logic [RECIP_W-1:0] RECIP_AREA_9  = 25'd1864136;
    localparam logic [RECIP_W-1:0] RECIP_AREA_25 = 25'd671089;
    localparam logic [RECIP_W-1:0] RECIP_AREA_49 = 25'd342393;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic                 fend;
    } bmf_meta_t;

    typedef struct packed {
        logic [PIX_W-1:0] mean;
        bmf_meta_t        meta;
    } bmf_result_t;

    // ceil(2^24 / (2r+1)^2); exact quotient for any window total below 2^14
    function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] radius);
        logic [RECIP_W-1:0] m;
        begin
            case (radius)
                2'd0:    m = RECIP_AREA_1;
                2'd1:    m = RECIP_AREA_9;
                2'd2:    m = RECIP_AREA_25;
                2'd3:    m = RECIP_AREA_49;
                default: m = RECIP_AREA_1;
            endcase
            return m;
        end
    endfunction

endpackage

// ===== rtl/bmf_line_cell.sv =====
// One history row of the line store: column memory, write forwarding and vertical sum step.
module bmf_line_cell #(
    parameter int MAX_WIDTH = bmf_pkg::DEF_MAX_WIDTH
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic                        wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  logic [bmf_pkg::PIX_W-1:0]   wr_data,
    input  logic                        use_row,
    input  logic [bmf_pkg::VSUM_W-1:0]  psum_in,
    output logic [bmf_pkg::VSUM_W-1:0]  psum_out,
    output logic [bmf_pkg::PIX_W-1:0]   cur_data
);

    logic [bmf_pkg::PIX_W-1:0] line_mem [0:MAX_WIDTH-1];
    logic [bmf_pkg::PIX_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_reg <= wr_data;
            end
            else
            begin
                rd_reg <= line_mem[rd_addr];
            end
        end
    end

    assign cur_data = rd_reg;
    assign psum_out = psum_in + (use_row ? bmf_pkg::VSUM_W'(rd_reg) : '0);

endmodule

// ===== rtl/bmf_sum_cell.sv =====
// One column-sum tap: holds a vertical sum, passes it on, and adds it into the window total.
module bmf_sum_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift_en,
    input  logic [bmf_pkg::VSUM_W-1:0]   tap_in,
    output logic [bmf_pkg::VSUM_W-1:0]   tap_out,
    input  logic                         use_tap,
    input  logic [bmf_pkg::TOTAL_W-1:0]  tot_in,
    output logic [bmf_pkg::TOTAL_W-1:0]  tot_out
);

    logic [bmf_pkg::VSUM_W-1:0] tap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
        end
        else if (shift_en)
        begin
            tap_reg <= tap_in;
        end
    end

    assign tap_out = tap_reg;
    assign tot_out = tot_in + (use_tap ? bmf_pkg::TOTAL_W'(tap_reg) : '0);

endmodule

// ===== rtl/bmf_out_fifo.sv =====
// Result queue between the filter pipeline and the output channel.
module bmf_out_fifo #(
    parameter int DEPTH = bmf_pkg::FIFO_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  bmf_pkg::bmf_result_t        push_data,
    input  logic                        pop_ready,
    output logic                        not_empty,
    output bmf_pkg::bmf_result_t        pop_data,
    output logic [$clog2(DEPTH+1)-1:0]  count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bmf_pkg::bmf_result_t entry_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign pop       = not_empty && pop_ready;
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/box_mean_filter_2d.sv =====
// Top level of the streaming 2-D box mean filter: config port, position counters, cell chains.
// Throughput: one pixel per cycle; input stalls only when the 8-entry result queue plus results
// still in the four pipeline stages would exceed the queue. A result is offered once it has
// passed line read, column shift, window total and multiply and entered the result queue.
// Reset: position, column sums, queue and config (radius 1, 1024 x 1024) clear at once;
// the line memories are not cleared and need no clearing pass.
module box_mean_filter_2d #(
    parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = bmf_pkg::DEF_MAX_RADIUS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bmf_pkg::PADDR_W-1:0]     paddr,
    input  logic [bmf_pkg::PDATA_W-1:0]     pwdata,
    output logic [bmf_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [bmf_pkg::PIX_W-1:0]       pixel,
    input  logic                            frame_start,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bmf_pkg::PIX_W-1:0]       mean_value,
    output logic [bmf_pkg::ROW_W-1:0]       center_row,
    output logic [bmf_pkg::COL_OUT_W-1:0]   center_col,
    output logic                            frame_end
);

    `include "box_mean_filter_2d_assert.svh"

    localparam int CPOS_W = $clog2(MAX_WIDTH);
    localparam int WE_W   = CPOS_W + 1;
    localparam int ROWS   = 2 * MAX_RADIUS;
    localparam int TAPS   = 2 * MAX_RADIUS + 1;
    localparam int DEPTH  = bmf_pkg::FIFO_DEPTH;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LOAD_W = CNT_W + 1;
    localparam int PROD_W = bmf_pkg::TOTAL_W + bmf_pkg::RECIP_W;

    logic [bmf_pkg::RAD_W-1:0] radius_reg;
    logic [bmf_pkg::FW_W-1:0]  width_reg;
    logic [bmf_pkg::FH_W-1:0]  height_reg;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= bmf_pkg::RADIUS_RESET;
            width_reg  <= bmf_pkg::WIDTH_RESET;
            height_reg <= bmf_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                bmf_pkg::REG_RADIUS: radius_reg <= pwdata[bmf_pkg::RAD_W-1:0];
                bmf_pkg::REG_WIDTH:  width_reg  <= pwdata[bmf_pkg::FW_W-1:0];
                bmf_pkg::REG_HEIGHT: height_reg <= pwdata[bmf_pkg::FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            bmf_pkg::REG_RADIUS: prdata = bmf_pkg::PDATA_W'(radius_reg);
            bmf_pkg::REG_WIDTH:  prdata = bmf_pkg::PDATA_W'(width_reg);
            bmf_pkg::REG_HEIGHT: prdata = bmf_pkg::PDATA_W'(height_reg);
            default:             prdata = '0;
        endcase
    end

    logic [bmf_pkg::RAD_W-1:0] r_eff;
    logic [bmf_pkg::IDX_W-1:0] two_r;
    logic [WE_W-1:0]           w_eff;
    logic [bmf_pkg::FH_W-1:0]  h_eff;

    always_comb
    begin
        r_eff = (32'(radius_reg) > MAX_RADIUS) ? bmf_pkg::RAD_W'(MAX_RADIUS) : radius_reg;
        two_r = {1'b0, r_eff, 1'b0};
        if (width_reg == '0)
        begin
            w_eff = WE_W'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = WE_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WE_W'(width_reg);
        end
        if (height_reg == '0)
        begin
            h_eff = bmf_pkg::FH_W'(1);
        end
        else if (32'(height_reg) > bmf_pkg::MAX_HEIGHT)
        begin
            h_eff = bmf_pkg::FH_W'(bmf_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    logic [CPOS_W-1:0]         col_pos_reg, col_pos_next;
    logic [bmf_pkg::ROW_W-1:0] row_pos_reg, row_pos_next;
    logic [CPOS_W-1:0]         col_raw, col_cur, ccol_full;
    logic [bmf_pkg::ROW_W-1:0] row_cur;
    logic [WE_W-1:0]           col_inc;
    logic [bmf_pkg::FH_W-1:0]  row_inc;
    logic                      emit;
    bmf_pkg::bmf_meta_t        meta_cur;
    logic                      in_accept;

    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        col_raw   = frame_start ? '0 : col_pos_reg;
        col_cur   = (32'(col_raw) >= MAX_WIDTH) ? '0 : col_raw;
        row_cur   = frame_start ? '0 : row_pos_reg;
        col_inc   = {1'b0, col_cur} + 1'b1;
        row_inc   = {1'b0, row_cur} + 1'b1;
        ccol_full = col_cur - CPOS_W'(r_eff);
        emit = ({1'b0, row_cur} < h_eff) && ({1'b0, col_cur} < w_eff)
            && (row_cur >= bmf_pkg::ROW_W'(two_r)) && (col_cur >= CPOS_W'(two_r));
        meta_cur.row  = row_cur - bmf_pkg::ROW_W'(r_eff);
        meta_cur.col  = bmf_pkg::COL_OUT_W'(ccol_full);
        meta_cur.fend = ({1'b0, row_cur} == (h_eff - 1'b1))
            && ({1'b0, col_cur} == (w_eff - 1'b1));
        if (col_inc >= w_eff)
        begin
            col_pos_next = '0;
            row_pos_next = (row_inc >= h_eff) ? '0 : row_inc[bmf_pkg::ROW_W-1:0];
        end
        else
        begin
            col_pos_next = col_inc[CPOS_W-1:0];
            row_pos_next = row_cur;
        end
    end

    logic                      s1_valid_reg, s1_emit_reg;
    logic [bmf_pkg::PIX_W-1:0] s1_pix_reg;
    logic [CPOS_W-1:0]         s1_col_reg;
    bmf_pkg::bmf_meta_t        s1_meta_reg;
    logic                      s2_valid_reg;
    bmf_pkg::bmf_meta_t        s2_meta_reg;
    logic                      s3_valid_reg;
    logic [bmf_pkg::TOTAL_W-1:0] s3_total_reg;
    bmf_pkg::bmf_meta_t        s3_meta_reg;
    logic                      s4_valid_reg;
    logic [bmf_pkg::PIX_W-1:0] s4_mean_reg;
    bmf_pkg::bmf_meta_t        s4_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                col_pos_reg <= col_pos_next;
                row_pos_reg <= row_pos_next;
            end
            s1_valid_reg <= in_accept;
            s1_emit_reg  <= in_accept && emit;
            s2_valid_reg <= s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // line store chain: each row hands its old value down to the next row
    logic [bmf_pkg::PIX_W-1:0]  line_val [0:ROWS-1];
    logic [bmf_pkg::PIX_W-1:0]  line_wr  [0:ROWS-1];
    logic [bmf_pkg::VSUM_W-1:0] psum     [0:ROWS];
    logic [bmf_pkg::VSUM_W-1:0] vsum;

    assign psum[0] = bmf_pkg::VSUM_W'(s1_pix_reg);
    assign vsum    = psum[ROWS];

    for (genvar k = 0; k < ROWS; k++)
    begin : g_line
        if (k == 0)
        begin : g_first
            assign line_wr[k] = s1_pix_reg;
        end
        else
        begin : g_rest
            assign line_wr[k] = line_val[k-1];
        end

        bmf_line_cell #(
            .MAX_WIDTH (MAX_WIDTH)
        ) u_line_cell (
            .clk      (clk),
            .rd_en    (in_accept),
            .rd_addr  (col_cur),
            .wr_en    (s1_valid_reg),
            .wr_addr  (s1_col_reg),
            .wr_data  (line_wr[k]),
            .use_row  (bmf_pkg::IDX_W'(k) < two_r),
            .psum_in  (psum[k]),
            .psum_out (psum[k+1]),
            .cur_data (line_val[k])
        );
    end

    // column sum chain: taps slide by one column per pixel
    logic [bmf_pkg::VSUM_W-1:0]  tap_val [0:TAPS-1];
    logic [bmf_pkg::VSUM_W-1:0]  tap_in  [0:TAPS-1];
    logic [bmf_pkg::TOTAL_W-1:0] tot     [0:TAPS];

    assign tot[0] = '0;

    for (genvar k = 0; k < TAPS; k++)
    begin : g_tap
        if (k == 0)
        begin : g_first
            assign tap_in[k] = vsum;
        end
        else
        begin : g_rest
            assign tap_in[k] = tap_val[k-1];
        end

        bmf_sum_cell u_sum_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (s1_valid_reg),
            .tap_in   (tap_in[k]),
            .tap_out  (tap_val[k]),
            .use_tap  (bmf_pkg::IDX_W'(k) <= two_r),
            .tot_in   (tot[k]),
            .tot_out  (tot[k+1])
        );
    end

    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(s3_total_reg) * PROD_W'(bmf_pkg::recip(r_eff));

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_pix_reg  <= pixel;
            s1_col_reg  <= col_cur;
            s1_meta_reg <= meta_cur;
        end
        s2_meta_reg  <= s1_meta_reg;
        s3_total_reg <= tot[TAPS];
        s3_meta_reg  <= s2_meta_reg;
        s4_mean_reg  <= prod[bmf_pkg::RECIP_SHIFT +: bmf_pkg::PIX_W];
        s4_meta_reg  <= s3_meta_reg;
    end

    bmf_pkg::bmf_result_t push_data, pop_data;
    logic [CNT_W-1:0]     fifo_count;
    logic [LOAD_W-1:0]    load;

    assign push_data.mean = s4_mean_reg;
    assign push_data.meta = s4_meta_reg;

    bmf_out_fifo #(
        .DEPTH (DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s4_valid_reg),
        .push_data (push_data),
        .pop_ready (out_ready),
        .not_empty (out_valid),
        .pop_data  (pop_data),
        .count     (fifo_count)
    );

    assign load = LOAD_W'(fifo_count) + LOAD_W'(s1_emit_reg) + LOAD_W'(s2_valid_reg)
        + LOAD_W'(s3_valid_reg) + LOAD_W'(s4_valid_reg);
    assign in_ready = (load < LOAD_W'(DEPTH));

    assign mean_value = pop_data.mean;
    assign center_row = pop_data.meta.row;
    assign center_col = pop_data.meta.col;
    assign frame_end  = pop_data.meta.fend;

    `BMF_ASSERT_IMPLY(a_credit_bound, 1'b1, load <= LOAD_W'(DEPTH), "result credit overrun")
    `BMF_ASSERT_IMPLY(a_no_drop, s4_valid_reg, fifo_count < CNT_W'(DEPTH), "push into full queue")
    `BMF_ASSERT_NEXT(a_accept_advance, in_accept, s1_valid_reg, "accepted word lost")

endmodule
